/* sv/mngm_pkg.sv */
`default_nettype none
package mngm_pkg;

	localparam int NUM_GATES = 8;
	localparam int CNT_W     = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
	localparam int GV_W      = (NUM_GATES > 8) ? NUM_GATES : 8;
	localparam int PV_W      = (CNT_W > 3) ? CNT_W : 3;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;

	localparam logic       OP_MIDI   = 1'b0;
	localparam logic       OP_TOGGLE = 1'b1;
	localparam logic [1:0] EV_NOTE_ON  = 2'd0;
	localparam logic [1:0] EV_NOTE_OFF = 2'd1;

	typedef struct packed {
		logic       op;
		logic [1:0] event_kind;
		logic [3:0] midi_channel;
		logic [6:0] note_number;
	} item_t;

	typedef struct packed {
		logic       led_blink;
		logic [2:0] learn_position;
		logic       learning;
		logic [7:0] gate_bits;
	} result_t;

	function automatic logic [7:0] gate_view(input logic [NUM_GATES-1:0] g);
		logic [GV_W-1:0] ext;
		ext = GV_W'(g);
		return ext[7:0];
	endfunction

	function automatic logic [2:0] pos_view(input logic [CNT_W-1:0] c);
		logic [PV_W-1:0] ext;
		ext = PV_W'(c);
		return ext[2:0];
	endfunction

endpackage
`default_nettype wire

/* sv/mngm_in_stage.sv */
`default_nettype none
module mngm_in_stage (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire  [mngm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	input  wire  [mngm_pkg::IN_USER_W-1:0]        s_axis_tuser,
	input  wire                                   advance,
	output logic                                  valid_s1,
	output mngm_pkg::item_t                       item_s1
);
	import mngm_pkg::*;

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op           <= s_axis_tuser[0];
			item_s1.event_kind   <= s_axis_tuser[2:1];
			item_s1.midi_channel <= s_axis_tdata[3:0];
			item_s1.note_number  <= s_axis_tdata[10:4];
		end
	end

endmodule
`default_nettype wire

/* sv/mngm_core.sv */
`default_nettype none
module mngm_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               advance,
	input  mngm_pkg::item_t   item,
	output mngm_pkg::result_t result_next
);
	import mngm_pkg::*;

	logic [3:0]           entry_channel_q [NUM_GATES];
	logic [6:0]           entry_note_q    [NUM_GATES];
	logic [NUM_GATES-1:0] gates_q;
	logic                 learn_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 led_q;

	logic [NUM_GATES-1:0] match;
	logic [NUM_GATES-1:0] gates_d;
	logic                 learn_d;
	logic [CNT_W-1:0]     cnt_d;
	logic                 led_d;
	logic                 store;

	always_comb begin
		for (int g = 0; g < NUM_GATES; g++) begin
			match[g] = (entry_channel_q[g] == item.midi_channel) &&
				(entry_note_q[g] == item.note_number);
		end
	end

	always_comb begin
		gates_d = gates_q;
		learn_d = learn_q;
		cnt_d   = cnt_q;
		led_d   = led_q;
		store   = 1'b0;
		if (item.op == OP_TOGGLE) begin
			cnt_d = '0;
			if (learn_q) begin
				learn_d = 1'b0;
				led_d   = 1'b0;
			end else begin
				learn_d = 1'b1;
				gates_d = '0;
				led_d   = 1'b1;
			end
		end else if (learn_q) begin
			if (item.event_kind == EV_NOTE_ON) begin
				store = 1'b1;
				if (cnt_q == CNT_W'(NUM_GATES - 1)) begin
					learn_d = 1'b0;
					cnt_d   = '0;
					led_d   = 1'b0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
		end else if (item.event_kind == EV_NOTE_ON) begin
			gates_d = gates_q | match;
		end else if (item.event_kind == EV_NOTE_OFF) begin
			gates_d = gates_q & ~match;
		end
	end

	always_comb begin
		result_next.gate_bits      = gate_view(gates_d);
		result_next.learning       = learn_d;
		result_next.learn_position = learn_d ? pos_view(cnt_d) : 3'd0;
		result_next.led_blink      = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gates_q <= '0;
			learn_q <= 1'b0;
			cnt_q   <= '0;
			led_q   <= 1'b0;
			for (int g = 0; g < NUM_GATES; g++) begin
				entry_channel_q[g] <= '0;
				entry_note_q[g]    <= '0;
			end
		end else if (advance) begin
			gates_q <= gates_d;
			learn_q <= learn_d;
			cnt_q   <= cnt_d;
			led_q   <= led_d;
			if (store) begin
				entry_channel_q[cnt_q] <= item.midi_channel;
				entry_note_q[cnt_q]    <= item.note_number;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/midi_note_gate_mapper_top.sv */
// MIDI note to gate mapper with learn mode.
// Input stream s_axis: one request per decoded MIDI event or learn toggle.
//   tuser carries op (toggle flag) and event_kind; tdata carries channel and note.
// Output stream m_axis: one result per input request, showing the gate bank,
//   learn flag, learn position and LED mode after that request took effect.
// Path: a request is captured in the input register, then the table lookup
//   and state update are registered into the result register.
// Throughput: one request per cycle while m_axis is not held, set by the
//   parallel compare against all gate entries.
// Reset (arst_n low): learned table cleared to channel 0 / note 0, gates off,
//   learn mode off, LED steady. Both stream sides come up empty.
// Stall: while m_axis is held, the result register keeps its value and one
//   more request can wait in the input register; after that s_axis_tready
//   drops until the result is taken. Nothing is lost or repeated.
`default_nettype none
module midi_note_gate_mapper_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// [3:0] midi_channel, [10:4] note_number, [15:11] zero
	input  wire  [mngm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [0] op, [2:1] event_kind
	input  wire  [mngm_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// [7:0] gate_bits, [8] learning, [11:9] learn_position, [12] led_blink, [15:13] zero
	output logic [mngm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import mngm_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t result_next;
	result_t result_q;
	logic    out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	mngm_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	mngm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.result_next (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(result_q);

	// learn mode and blinking LED always go together
	a_led_learn: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8] == m_axis_tdata[12]))
		else $error("led mode disagrees with learn flag");

	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[11:9] == 3'd0))
		else $error("learn position nonzero outside learn mode");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while both stages are full");

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("result missing after an advance");

endmodule
`default_nettype wire

/* tb/gate_map_monitor.sv */
`timescale 1ns / 1ps

module gate_map_monitor (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	input  wire                                s_tready,
	// [3:0] midi_channel, [10:4] note_number, [15:11] zero
	input  wire  [mngm_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] op, [2:1] event_kind
	input  wire  [mngm_pkg::IN_USER_W-1:0]     s_tuser,
	input  wire                                m_tvalid,
	input  wire                                m_tready,
	// [7:0] gate_bits, [8] learning, [11:9] learn_position, [12] led_blink, [15:13] zero
	input  wire  [mngm_pkg::OUT_DATA_W-1:0]    m_tdata,
	output int                                 mismatches,
	output int                                 pending
);
	import mngm_pkg::*;

	logic [3:0]           learned_chan [NUM_GATES];
	logic [6:0]           learned_note [NUM_GATES];
	logic [NUM_GATES-1:0] gates;
	logic                 learn_on;
	int                   learn_idx;
	logic                 blink;
	result_t              status_q [$];

	task automatic report(input string field, input int got, input int want);
		$display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
		mismatches++;
	endtask

	function automatic result_t apply_midi_event(input item_t it);
		result_t      r;
		logic [31:0]  wide;
		logic [31:0]  pos;
		if (it.op == OP_TOGGLE) begin
			if (learn_on) begin
				learn_on  = 1'b0;
				learn_idx = 0;
				blink     = 1'b0;
			end else begin
				learn_on  = 1'b1;
				learn_idx = 0;
				gates     = '0;
				blink     = 1'b1;
			end
		end else if (learn_on) begin
			if (it.event_kind == EV_NOTE_ON) begin
				if (learn_idx < NUM_GATES) begin
					learned_chan[learn_idx] = it.midi_channel;
					learned_note[learn_idx] = it.note_number;
				end
				learn_idx++;
				if (learn_idx >= NUM_GATES) begin
					learn_on  = 1'b0;
					learn_idx = 0;
					blink     = 1'b0;
				end
			end
		end else if (it.event_kind == EV_NOTE_ON || it.event_kind == EV_NOTE_OFF) begin
			for (int g = 0; g < NUM_GATES; g++) begin
				if (learned_chan[g] == it.midi_channel && learned_note[g] == it.note_number)
					gates[g] = (it.event_kind == EV_NOTE_ON);
			end
		end
		wide             = 32'(gates);
		pos              = learn_on ? 32'(learn_idx) : 32'd0;
		r.gate_bits      = wide[7:0];
		r.learning       = learn_on;
		r.learn_position = pos[2:0];
		r.led_blink      = blink;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int g = 0; g < NUM_GATES; g++) begin
				learned_chan[g] = '0;
				learned_note[g] = '0;
			end
			gates      = '0;
			learn_on   = 1'b0;
			learn_idx  = 0;
			blink      = 1'b0;
			mismatches = 0;
			status_q.delete();
			pending    = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				it.op           = s_tuser[0];
				it.event_kind   = s_tuser[2:1];
				it.midi_channel = s_tdata[3:0];
				it.note_number  = s_tdata[10:4];
				status_q.push_back(apply_midi_event(it));
			end
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					report("result with no request pending", m_tdata, 0);
				end else begin
					want = status_q.pop_front();
					got  = result_t'(m_tdata[12:0]);
					if (got.gate_bits != want.gate_bits)
						report("gate_bits", got.gate_bits, want.gate_bits);
					if (got.learning != want.learning)
						report("learning", got.learning, want.learning);
					if (got.learn_position != want.learn_position)
						report("learn_position", got.learn_position, want.learn_position);
					if (got.led_blink != want.led_blink)
						report("led_blink", got.led_blink, want.led_blink);
					if (m_tdata[15:13] != 3'b000)
						report("tdata padding", m_tdata[15:13], 0);
				end
			end
			pending = status_q.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mngm_pkg::*;

	localparam logic [1:0] EV_OTHER    = 2'd2;
	localparam logic [1:0] EV_RESERVED = 2'd3;
	localparam int         TARGET_REQS = 850;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	wire                   s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	wire                   m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	wire  [OUT_DATA_W-1:0] m_axis_tdata;

	int   mismatches;
	int   pending;
	int   sent_count = 0;
	bit   quiet = 1'b0;
	bit   drained = 1'b0;
	logic [3:0] pool_chan [8];
	logic [6:0] pool_note [8];

	always #10 clk = ~clk;

	midi_note_gate_mapper_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	gate_map_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic send_event(input logic op, input logic [1:0] kind,
			input logic [3:0] chan, input logic [6:0] note);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b00000, note, chan};
		s_axis_tuser  <= {kind, op};
		do @(posedge clk); while (!s_axis_tready);
		sent_count++;
	endtask

	task automatic send_toggle();
		send_event(OP_TOGGLE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
			7'($urandom_range(0, 127)));
	endtask

	task automatic send_noise();
		logic [1:0] kind;
		kind = ($urandom_range(0, 1) == 0) ? EV_NOTE_OFF
			: (($urandom_range(0, 1) == 0) ? EV_OTHER : EV_RESERVED);
		send_event(OP_MIDI, kind, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic learn_session();
		int idx;
		for (int i = 0; i < 8; i++) begin
			pool_chan[i] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(0, 2));
			pool_note[i] = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(60, 63));
		end
		send_toggle();
		idx = 0;
		while (idx < 8) begin
			case ($urandom_range(0, 19))
				0, 1: send_noise();
				2: begin
					send_toggle();
					return;
				end
				default: begin
					send_event(OP_MIDI, EV_NOTE_ON, pool_chan[idx], pool_note[idx]);
					idx++;
				end
			endcase
		end
	endtask

	task automatic play_session();
		int k;
		for (int i = 0; i < 20; i++) begin
			k = $urandom_range(0, 19);
			if (k < 15)
				send_event(OP_MIDI, ($urandom_range(0, 1) == 0) ? EV_NOTE_ON : EV_NOTE_OFF,
					pool_chan[k % 8], pool_note[k % 8]);
			else if (k < 18)
				send_event(OP_MIDI, ($urandom_range(0, 1) == 0) ? EV_NOTE_ON : EV_NOTE_OFF,
					4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
			else
				send_noise();
		end
	endtask

	initial begin
		forever begin
			int stall;
			wait (arst_n);
			stall = quiet ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		for (int i = 0; i < 8; i++) begin
			pool_chan[i] = '0;
			pool_note[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared table: channel 0 / note 0 hits every gate
		send_event(OP_MIDI, EV_NOTE_ON, 4'd0, 7'd0);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_OTHER, 4'd0, 7'd0);
		send_event(OP_MIDI, EV_RESERVED, 4'd0, 7'd0);
		send_event(OP_MIDI, EV_NOTE_OFF, 4'd0, 7'd0);
		send_event(OP_TOGGLE, EV_RESERVED, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_NOTE_OFF, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_OTHER, 4'd9, 7'd64);
		send_event(OP_MIDI, EV_RESERVED, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd0, 7'd0);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd5, 7'd42);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd10, 7'd85);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd15, 7'd0);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd0, 7'd127);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd3, 7'd3);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd15, 7'd127);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd5, 7'd42);
		send_event(OP_MIDI, EV_NOTE_OFF, 4'd15, 7'd127);
		send_event(OP_TOGGLE, EV_NOTE_OFF, 4'd10, 7'd85);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd5, 7'd42);
		send_event(OP_TOGGLE, EV_OTHER, 4'd0, 7'd0);
		send_event(OP_MIDI, EV_NOTE_ON, 4'd10, 7'd85);

		while (sent_count < TARGET_REQS) begin
			if (!drained && sent_count >= TARGET_REQS / 2) begin
				wait_all_results();
				drained = 1'b1;
			end
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2: learn_session();
				9: send_toggle();
				default: play_session();
			endcase
		end

		wait_all_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
